// File: rtl/core/range_rule_packet_filter_core_macros.svh
// range_rule_packet_filter_core_macros.svh: assertion macros for the rule filter checker
// depends on signals i_clk and i_rst_n in the scope that expands them
`ifndef RANGE_RULE_PACKET_FILTER_CORE_MACROS_SVH
`define RANGE_RULE_PACKET_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RRPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RRPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rrpf_pkg.sv
// rrpf_pkg: beat types, codes and helpers for the range rule packet filter
// no dependencies
package rrpf_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_CHK = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_ACCEPT   = 3'd5;
    localparam logic [2:0] ST_REJECT   = 3'd6;
    localparam logic [2:0] ST_ILLEGAL  = 3'd7;

    localparam logic [15:0] PORT_TOP = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] range_lo_addr;
        logic [31:0] range_hi_addr;
        logic [15:0] range_lo_port;
        logic [15:0] range_hi_port;
        logic [31:0] probe_addr;
        logic [15:0] probe_port;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] status;
        logic       hit;
        logic [5:0] hit_index;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] addr_lo;
        logic [31:0] addr_hi;
        logic [15:0] port_lo;
        logic [15:0] port_hi;
    } t_rule;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic add_en;
        logic shift_en;
        logic del_mode;
    } t_cell_ctl;

    function automatic logic bad_ports(input logic [15:0] plo, input logic [15:0] phi);
        return (plo == 16'd0) || (phi == PORT_TOP) || (plo > phi);
    endfunction

endpackage

// File: rtl/core/rrpf_cell.sv
// rrpf_cell: one rule slot of the filter chain with its stage of the first-match wave
// depends on rrpf_pkg
module rrpf_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrpf_pkg::t_cell_ctl i_ctl,
    input  rrpf_pkg::t_rule    i_cmd_rule,
    input  logic [31:0]        i_probe_addr,
    input  logic [15:0]        i_probe_port,
    input  logic [CW-1:0]      i_count,
    input  logic [IW-1:0]      i_del_idx,
    input  rrpf_pkg::t_rule    i_next_rule,
    input  logic               i_prev_found,
    input  logic [IW-1:0]      i_prev_idx,
    output rrpf_pkg::t_rule    o_rule,
    output logic               o_found,
    output logic [IW-1:0]      o_idx
);

    rrpf_pkg::t_rule r_rule;
    rrpf_pkg::t_rule n_rule;
    logic            r_found;
    logic            n_found;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   n_idx;
    logic            live;
    logic            hit_range;
    logic            hit_exact;
    logic            match;

    assign live = CW'(IDX) < i_count;

    assign hit_range = (i_probe_addr >= r_rule.addr_lo) && (i_probe_addr <= r_rule.addr_hi) &&
                       (i_probe_port >= r_rule.port_lo) && (i_probe_port <= r_rule.port_hi);
    assign hit_exact = (r_rule == i_cmd_rule);
    assign match     = live && (i_ctl.del_mode ? hit_exact : hit_range);

    always_comb begin
        n_rule = r_rule;
        if (i_ctl.add_en && (i_count == CW'(IDX))) begin
            n_rule = i_cmd_rule;
        end else if (i_ctl.shift_en && (IW'(IDX) >= i_del_idx)) begin
            n_rule = i_next_rule;
        end
    end

    // wave: pass an earlier hit along, else claim this slot
    always_comb begin
        if (i_prev_found) begin
            n_found = 1'b1;
            n_idx   = i_prev_idx;
        end else if (match) begin
            n_found = 1'b1;
            n_idx   = IW'(IDX);
        end else begin
            n_found = 1'b0;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rule <= n_rule;
        r_idx  <= n_idx;
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    assign o_rule  = r_rule;
    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

// File: rtl/core/range_rule_packet_filter_core.sv
// range_rule_packet_filter_core: first-match range rule table built as a chain of rule cells
// flow: a taken beat is registered, checked in S_EVAL and answered in S_RESP, which loads the
// output register; a delete or check passes S_SCAN first while the first-match wave walks one
// cell per cycle; no beat is taken until S_RESP is done, and S_RESP waits while the output stalls
// reset: synchronous active low, empties the table (rule count zero), output beat dropped
// depends on rrpf_pkg and rrpf_cell
module range_rule_packet_filter_core #(
    parameter int MAX_RULES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rrpf_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rrpf_pkg::t_out_beat o_out_data
);

    localparam int IW = $clog2(MAX_RULES);
    localparam int CW = $clog2(MAX_RULES + 1);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    rrpf_pkg::t_in_beat  r_cmd;
    rrpf_pkg::t_in_beat  n_cmd;
    logic [2:0]          r_status;
    logic [2:0]          n_status;
    logic                r_scan;
    logic                n_scan;
    logic [IW-1:0]       r_cnt;
    logic [IW-1:0]       n_cnt;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    rrpf_pkg::t_out_beat r_out;
    rrpf_pkg::t_out_beat n_out;
    logic                r_out_valid;
    logic                n_out_valid;

    rrpf_pkg::t_cell_ctl ctl;
    rrpf_pkg::t_rule     cmd_rule;
    rrpf_pkg::t_rule     rules  [MAX_RULES];
    logic                found  [MAX_RULES+1];
    logic [IW-1:0]       idx    [MAX_RULES+1];
    logic                last_found;
    logic [IW-1:0]       last_idx;
    logic [IW+5:0]       idx_ext;

    assign cmd_rule.addr_lo = r_cmd.range_lo_addr;
    assign cmd_rule.addr_hi = r_cmd.range_hi_addr;
    assign cmd_rule.port_lo = r_cmd.range_lo_port;
    assign cmd_rule.port_hi = r_cmd.range_hi_port;

    // head of the wave never carries a hit
    assign found[0] = 1'b0;
    assign idx[0]   = '0;

    // the chain: cell i holds rule i; match wave moves toward the tail one cell per cycle,
    // a delete pulls every rule behind the removed one up by one place
    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        rrpf_pkg::t_rule next_rule;
        if (g == MAX_RULES - 1) begin : g_tail
            assign next_rule = rules[g];
        end else begin : g_body
            assign next_rule = rules[g+1];
        end
        rrpf_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_cmd_rule   (cmd_rule),
            .i_probe_addr (r_cmd.probe_addr),
            .i_probe_port (r_cmd.probe_port),
            .i_count      (r_count),
            .i_del_idx    (last_idx),
            .i_next_rule  (next_rule),
            .i_prev_found (found[g]),
            .i_prev_idx   (idx[g]),
            .o_rule       (rules[g]),
            .o_found      (found[g+1]),
            .o_idx        (idx[g+1])
        );
    end

    // tail of the chain holds the first match once the wave has run through
    assign last_found = found[MAX_RULES];
    assign last_idx   = idx[MAX_RULES];
    // hit_index carries the low six bits of the position
    assign idx_ext    = {6'd0, last_idx};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_scan      = r_scan;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ctl         = '0;
        ctl.del_mode = (r_cmd.operation == rrpf_pkg::OP_DEL);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_cnt  = '0;
                n_scan = 1'b0;
                n_state = S_RESP;
                case (r_cmd.operation)
                    rrpf_pkg::OP_ADD: begin
                        if (rrpf_pkg::bad_ports(r_cmd.range_lo_port, r_cmd.range_hi_port)) begin
                            n_status = rrpf_pkg::ST_INVALID;
                        end else if (r_count == CW'(MAX_RULES)) begin
                            n_status = rrpf_pkg::ST_FULL;
                        end else begin
                            n_status = rrpf_pkg::ST_ADDED;
                        end
                    end
                    rrpf_pkg::OP_DEL: begin
                        if (rrpf_pkg::bad_ports(r_cmd.range_lo_port, r_cmd.range_hi_port)) begin
                            n_status = rrpf_pkg::ST_INVALID;
                        end else begin
                            n_scan  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                    rrpf_pkg::OP_CHK: begin
                        if ((r_cmd.probe_port == 16'd0) ||
                            (r_cmd.probe_port == rrpf_pkg::PORT_TOP)) begin
                            n_status = rrpf_pkg::ST_ILLEGAL;
                        end else begin
                            n_scan  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_status = rrpf_pkg::ST_ILLEGAL;
                    end
                endcase
            end
            S_SCAN: begin
                // command is steady since eval, so the tail is settled after this count
                if (r_cnt == IW'(MAX_RULES - 1)) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RESP: begin
                // commit table change together with loading the output register
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.hit       = 1'b0;
                    n_out.hit_index = '0;
                    if (r_scan) begin
                        if (r_cmd.operation == rrpf_pkg::OP_DEL) begin
                            if (last_found) begin
                                n_out.status = rrpf_pkg::ST_DELETED;
                                ctl.shift_en = 1'b1;
                                n_count      = r_count - 1'b1;
                            end else begin
                                n_out.status = rrpf_pkg::ST_NOTFOUND;
                            end
                        end else if (last_found) begin
                            n_out.status    = rrpf_pkg::ST_ACCEPT;
                            n_out.hit       = 1'b1;
                            n_out.hit_index = idx_ext[5:0];
                        end else begin
                            n_out.status = rrpf_pkg::ST_REJECT;
                        end
                    end else if (r_status == rrpf_pkg::ST_ADDED) begin
                        ctl.add_en = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_scan   <= n_scan;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // input is taken only while the sequencer is free; the output register decouples the sink
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/rrpf_checker.sv
// rrpf_checker: port-level assertions for the range rule packet filter, bound to the top
// depends on rrpf_pkg and range_rule_packet_filter_core_macros.svh
`include "range_rule_packet_filter_core_macros.svh"

module rrpf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rrpf_pkg::t_out_beat o_out_data
);

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // a stalled result beat holds
    `RRPF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "output beat changed under stall")

    // hit flag goes with accepted status and nothing else
    `RRPF_ASSERT_SAME(a_hit_status, o_out_valid, o_out_data.hit == (o_out_data.status == rrpf_pkg::ST_ACCEPT), "hit and status disagree")

    // no hit means a zero index
    `RRPF_ASSERT_SAME(a_idx_zero, o_out_valid && !o_out_data.hit, o_out_data.hit_index == 6'd0, "index set without hit")

    // one beat at a time: a taken beat closes the input
    `RRPF_ASSERT_NEXT(a_one_beat, in_take, o_in_stall, "input open right after a beat")

endmodule

bind range_rule_packet_filter_core rrpf_checker u_rrpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/sv/range_rule_packet_filter_core_tb.sv
// range_rule_packet_filter_core_tb: self-checking bench for the first-match range rule filter
// holds a rule-table scoreboard class plus stimulus, receiver and watchdog processes
// depends on rrpf_pkg and range_rule_packet_filter_core
module range_rule_packet_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RULES = 64;

    // operation code the block does not define, answered as illegal
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // sizes of the run
    localparam int RANDOM_ITEMS = 1950;
    localparam int MAX_GAP = 13;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_AT_RESULT = 400;
    localparam int DRAIN_AT_ITEM = 1100;
    localparam int TAIL_CYCLES = MAX_RULES + 10;

    // scoreboard: a shadow rule table and the queue of verdicts still owed
    class filter_scoreboard;
        rrpf_pkg::t_rule     rules[MAX_RULES];
        int unsigned         count;
        rrpf_pkg::t_out_beat owed_verdicts[$];
        int unsigned         errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function bit ports_rejected(input logic [15:0] plo, input logic [15:0] phi);
            return (plo == 16'd0) || (phi == rrpf_pkg::PORT_TOP) || (plo > phi);
        endfunction

        // applies one beat to the shadow table and returns the verdict it earns
        function rrpf_pkg::t_out_beat table_verdict(input rrpf_pkg::t_in_beat b);
            rrpf_pkg::t_out_beat v;
            rrpf_pkg::t_rule     key;
            bit                  found;
            v.status    = rrpf_pkg::ST_ILLEGAL;
            v.hit       = 1'b0;
            v.hit_index = '0;
            key.addr_lo = b.range_lo_addr;
            key.addr_hi = b.range_hi_addr;
            key.port_lo = b.range_lo_port;
            key.port_hi = b.range_hi_port;
            found       = 1'b0;
            case (b.operation)
                rrpf_pkg::OP_ADD: begin
                    if (ports_rejected(key.port_lo, key.port_hi)) begin
                        v.status = rrpf_pkg::ST_INVALID;
                    end else if (count >= MAX_RULES) begin
                        v.status = rrpf_pkg::ST_FULL;
                    end else begin
                        rules[count] = key;
                        count++;
                        v.status = rrpf_pkg::ST_ADDED;
                    end
                end
                rrpf_pkg::OP_DEL: begin
                    if (ports_rejected(key.port_lo, key.port_hi)) begin
                        v.status = rrpf_pkg::ST_INVALID;
                    end else begin
                        v.status = rrpf_pkg::ST_NOTFOUND;
                        for (int i = 0; i < count; i++) begin
                            if (!found && rules[i] == key) begin
                                found = 1'b1;
                            end
                            // rules behind the removed one move up a place
                            if (found && i + 1 < count) begin
                                rules[i] = rules[i + 1];
                            end
                        end
                        if (found) begin
                            count--;
                            v.status = rrpf_pkg::ST_DELETED;
                        end
                    end
                end
                rrpf_pkg::OP_CHK: begin
                    if (b.probe_port == 16'd0 || b.probe_port == rrpf_pkg::PORT_TOP) begin
                        v.status = rrpf_pkg::ST_ILLEGAL;
                    end else begin
                        v.status = rrpf_pkg::ST_REJECT;
                        for (int i = 0; i < count; i++) begin
                            if (!found &&
                                b.probe_addr >= rules[i].addr_lo &&
                                b.probe_addr <= rules[i].addr_hi &&
                                b.probe_port >= rules[i].port_lo &&
                                b.probe_port <= rules[i].port_hi) begin
                                found       = 1'b1;
                                v.status    = rrpf_pkg::ST_ACCEPT;
                                v.hit       = 1'b1;
                                v.hit_index = 6'(i);
                            end
                        end
                    end
                end
                default: begin
                    v.status = rrpf_pkg::ST_ILLEGAL;
                end
            endcase
            return v;
        endfunction

        function void note_beat(input rrpf_pkg::t_in_beat b);
            owed_verdicts.push_back(table_verdict(b));
        endfunction

        function void check_beat(input rrpf_pkg::t_out_beat got);
            rrpf_pkg::t_out_beat want;
            if (owed_verdicts.size() == 0) begin
                $error("unexpected result beat: status %0d hit %0d hit_index %0d",
                       got.status, got.hit, got.hit_index);
                errors++;
                return;
            end
            want = owed_verdicts.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.hit_index !== want.hit_index) begin
                $error("hit_index: expected %0d, actual %0d", want.hit_index, got.hit_index);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    rrpf_pkg::t_in_beat  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    rrpf_pkg::t_out_beat o_out_data;

    filter_scoreboard sb;

    // sender and receiver idling switch on and off in stretches
    bit          send_idle_on;
    bit          recv_idle_on;
    int unsigned results_seen;
    int unsigned idle_cycles;

    range_rule_packet_filter_core #(
        .MAX_RULES(MAX_RULES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // one beat on the input channel: optional gap, then hold until accepted
    // each call starts at the falling edge right after the previous acceptance
    task automatic send_beat(input rrpf_pkg::t_in_beat b);
        int unsigned gap;
        gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        for (int g = 0; g < gap; g++) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(b);
    endtask

    // drop valid, then sit until every owed verdict has come back
    task automatic wait_drained();
        @(negedge i_clk) i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // builds a well-formed beat for directed use
    function automatic rrpf_pkg::t_in_beat beat_of(input logic [1:0] op,
                                         input logic [31:0] alo, input logic [31:0] ahi,
                                         input logic [15:0] plo, input logic [15:0] phi,
                                         input logic [31:0] paddr, input logic [15:0] pport);
        rrpf_pkg::t_in_beat b;
        b.operation     = op;
        b.range_lo_addr = alo;
        b.range_hi_addr = ahi;
        b.range_lo_port = plo;
        b.range_hi_port = phi;
        b.probe_addr    = paddr;
        b.probe_port    = pport;
        return b;
    endfunction

    // random rule with legal ports; address span narrow, wide, whole or single
    function automatic rrpf_pkg::t_rule random_rule();
        rrpf_pkg::t_rule r;
        int unsigned     m;
        int unsigned     span;
        m         = $urandom_range(0, 99);
        r.addr_lo = $urandom;
        if (m < 50) begin
            span      = $urandom_range(0, 4095);
            r.addr_hi = (r.addr_lo > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : r.addr_lo + span;
        end else if (m < 80) begin
            // fully random, reversed about half the time
            r.addr_hi = $urandom;
        end else if (m < 90) begin
            r.addr_lo = 32'h0000_0000;
            r.addr_hi = 32'hFFFF_FFFF;
        end else begin
            r.addr_hi = r.addr_lo;
        end
        r.port_lo = 16'($urandom_range(1, 65534));
        if ($urandom_range(0, 1) == 0) begin
            r.port_hi = 16'($urandom_range(r.port_lo, 65534));
        end else begin
            span      = $urandom_range(0, 1000);
            r.port_hi = (r.port_lo + span > 65534) ? 16'd65534 : 16'(r.port_lo + span);
        end
        return r;
    endfunction

    // random beat shaped by phase: 0 fill, 1 balanced, 2 drain, 3 check heavy
    // unused fields always carry random noise
    function automatic rrpf_pkg::t_in_beat random_beat(input int unsigned phase);
        rrpf_pkg::t_in_beat b;
        rrpf_pkg::t_rule    r;
        int unsigned        pick;
        int unsigned        sel;
        int unsigned        add_cut;
        int unsigned        del_cut;
        longint unsigned    span;
        b.operation     = 2'($urandom);
        b.range_lo_addr = $urandom;
        b.range_hi_addr = $urandom;
        b.range_lo_port = 16'($urandom);
        b.range_hi_port = 16'($urandom);
        b.probe_addr    = $urandom;
        b.probe_port    = 16'($urandom);
        case (phase)
            0: begin add_cut = 70; del_cut = 80; end
            1: begin add_cut = 35; del_cut = 60; end
            2: begin add_cut = 15; del_cut = 65; end
            default: begin add_cut = 20; del_cut = 35; end
        endcase
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (pick < add_cut) begin
            b.operation = rrpf_pkg::OP_ADD;
            r = random_rule();
            if (sel < 90) begin
                // keep the good rule
            end else if (sel < 94) begin
                r.port_lo = 16'd0;
            end else if (sel < 97) begin
                r.port_hi = rrpf_pkg::PORT_TOP;
            end else begin
                r.port_lo = 16'($urandom_range(2, 65534));
                r.port_hi = 16'($urandom_range(1, r.port_lo - 1));
            end
            {b.range_lo_addr, b.range_hi_addr, b.range_lo_port, b.range_hi_port} = r;
        end else if (pick < del_cut) begin
            b.operation = rrpf_pkg::OP_DEL;
            if (sb.count > 0 && sel < 60) begin
                r = sb.rules[$urandom_range(0, sb.count - 1)];
            end else if (sb.count > 0 && sel < 75) begin
                // near miss on one address bit
                r = sb.rules[$urandom_range(0, sb.count - 1)];
                r.addr_hi = r.addr_hi ^ (32'd1 << $urandom_range(0, 31));
            end else if (sel < 88) begin
                r = random_rule();
            end else begin
                r = random_rule();
                if (sel < 94) r.port_lo = 16'd0;
                else r.port_hi = rrpf_pkg::PORT_TOP;
            end
            {b.range_lo_addr, b.range_hi_addr, b.range_lo_port, b.range_hi_port} = r;
        end else if (pick < 97) begin
            b.operation = rrpf_pkg::OP_CHK;
            if (sb.count > 0 && sel < 70) begin
                // aim inside a held rule
                r = sb.rules[$urandom_range(0, sb.count - 1)];
                b.probe_port = 16'($urandom_range(r.port_lo, r.port_hi));
                if (r.addr_lo <= r.addr_hi) begin
                    span = longint'(r.addr_hi) - longint'(r.addr_lo) + 1;
                    b.probe_addr = 32'(longint'(r.addr_lo) + (longint'($urandom) % span));
                end
            end else if (sel < 94) begin
                b.probe_port = 16'($urandom_range(1, 65534));
            end else if (sel < 97) begin
                b.probe_port = 16'd0;
            end else begin
                b.probe_port = rrpf_pkg::PORT_TOP;
            end
        end else begin
            b.operation = OP_UNUSED;
        end
        return b;
    endfunction

    // receiver: random hold-off before each beat, one long hold-off mid run
    task automatic receive_results();
        int unsigned gap;
        forever begin
            if (results_seen % 100 == 0) begin
                recv_idle_on = ($urandom_range(0, 2) != 0);
            end
            gap = recv_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            for (int g = 0; g < gap; g++) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
            end
            @(negedge i_clk) i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_beat(o_out_data);
            results_seen++;
            // long back-pressure so the block fills and stalls its input
            if (results_seen == HOLD_AT_RESULT) begin
                for (int h = 0; h < LONG_HOLD; h++) begin
                    @(negedge i_clk) i_out_stall <= 1'b1;
                end
            end
        end
    endtask

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        results_seen = 0;
        idle_cycles  = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        fork
            receive_results();
        join_none

        // directed part on an empty table
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'h0000_0000, 16'd1));
        // probe on port 0 and port 65535
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'h0A00_0001, 16'd0));
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'hFFFF_FFFF,
                          rrpf_pkg::PORT_TOP));
        // bad port bounds on add and delete
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 16'd0, 16'd100, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 16'd1, rrpf_pkg::PORT_TOP,
                          '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 16'd500, 16'd499, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_DEL, 32'h0, 32'hFFFF_FFFF, 16'd0, 16'd100, '0, '0));
        // whole address space with the widest legal ports
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd65534, '0, '0));
        // reversed address range, never matches
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0, 16'd1, 16'd65534, '0, '0));
        // duplicate of the first rule
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd65534, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_ADD, 32'h0A00_0000, 32'h0A00_00FF, 16'd80, 16'd80,
                          '0, '0));
        // edge addresses and edge ports hit the first rule
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'hFFFF_FFFF, 16'd65534));
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'h0000_0000, 16'd1));
        // delete takes the first copy only
        send_beat(beat_of(rrpf_pkg::OP_DEL, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd65534, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'h0A00_0005, 16'd80));
        send_beat(beat_of(rrpf_pkg::OP_DEL, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd65534, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_DEL, 32'h0, 32'hFFFF_FFFF, 16'd1, 16'd65534, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'h0A00_0005, 16'd80));
        send_beat(beat_of(rrpf_pkg::OP_CHK, '0, '0, '0, '0, 32'h0A00_0100, 16'd80));
        // undefined operation with every field at all ones
        send_beat(beat_of(OP_UNUSED, '1, '1, '1, '1, '1, '1));
        send_beat(beat_of(rrpf_pkg::OP_DEL, 32'h0A00_0000, 32'h0A00_00FF, 16'd80,
                          rrpf_pkg::PORT_TOP, '0, '0));
        send_beat(beat_of(rrpf_pkg::OP_DEL, 32'h0A00_0000, 32'h0A00_00FF, 16'd81, 16'd80,
                          '0, '0));
        wait_drained();

        // random part, phases cycle through fill, balanced, drain and check heavy
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0) begin
                send_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (k == DRAIN_AT_ITEM) begin
                wait_drained();
            end
            send_beat(random_beat((k / 150) % 4));
        end
        @(negedge i_clk) i_in_valid <= 1'b0;

        // let everything owed arrive, then watch for strays
        @(posedge i_clk);
        while (sb.owed_verdicts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.owed_verdicts.size() != 0) begin
            $error("results missing: %0d still owed", sb.owed_verdicts.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rrpf_pkg.sv
rtl/core/rrpf_cell.sv
rtl/core/range_rule_packet_filter_core.sv
rtl/core/rrpf_checker.sv
tb/sv/range_rule_packet_filter_core_tb.sv
